// File: rtl/dwsc_pkg.sv
// Shared types and constants of the dual-wheel speed PI controller.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package dwsc_pkg;

  // encoder slots per wheel revolution
  localparam int SLOTS_PER_REV = 30;

  localparam int PULSE_W  = 10;
  localparam int PERIOD_W = 16;
  localparam int SPEED_W  = 16;
  localparam int DUTY_W   = 8;
  localparam int GAIN_W   = 16;
  localparam int ACC_W    = 32;
  localparam int TIME_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // speed = pulses * 1000 * 4096 / (slots * period)
  localparam int NUM_W  = 32;
  localparam int DEN_W  = PERIOD_W + $clog2(SLOTS_PER_REV + 1);
  localparam int DIV_W  = DEN_W + SPEED_W;
  localparam int BIT_W  = $clog2(SPEED_W);
  localparam logic [NUM_W-1:0] NUM_SCALE = NUM_W'(4096000);

  // |x| / 1000 for x below 2^32: (x * M) >> 38
  localparam int RECIP_W  = 29;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(274877907);
  localparam int RECIP_SH = 38;
  localparam int RP_W     = NUM_W + RECIP_W;
  localparam int QUO_W    = RP_W - RECIP_SH;

  localparam int ERR_W   = SPEED_W + 1;
  localparam int PTERM_W = ERR_W + GAIN_W + 1;
  localparam int ITERM_W = ACC_W + GAIN_W + 1;
  localparam int FRAC_W  = 20;
  localparam int TOTAL_W = ITERM_W + 2;

  localparam logic [TIME_W-1:0] STEP_START_MS = TIME_W'(2000);
  localparam logic [TIME_W-1:0] STEP_LEN_MS   = TIME_W'(10000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_MODE   = 3'd0,
    CFG_TARGET_L    = 3'd1,
    CFG_TARGET_R    = 3'd2,
    CFG_PROP_GAIN_L = 3'd3,
    CFG_INT_GAIN_L  = 3'd4,
    CFG_PROP_GAIN_R = 3'd5,
    CFG_INT_GAIN_R  = 3'd6,
    CFG_STEP_DRIVE  = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,     // capture input beat, period scale, time update
    OP_NUM,      // dividend for selected wheel
    OP_CHK,      // saturation check, clear quotient
    OP_DIV,      // one restoring division step
    OP_SPD,      // store speed of selected wheel
    OP_ERR,      // speed error
    OP_MUL,      // error * period
    OP_RCP,      // divide by 1000
    OP_ACC,      // integral update with saturation
    OP_PROD,     // gain products
    OP_DUTY,     // new duty
    OP_STEP,     // step-test sequencing
    OP_OUT       // load result register
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic             wheel;   // 0 left, 1 right
    logic [BIT_W-1:0] bit_idx;
  } dwsc_cmd_t;

  typedef struct packed {
    logic step_mode;
  } dwsc_sts_t;

  typedef struct packed {
    logic [PULSE_W-1:0]  pulses_left;
    logic [PULSE_W-1:0]  pulses_right;
    logic [PERIOD_W-1:0] period_ms;
  } dwsc_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  drive_left;
    logic [DUTY_W-1:0]  drive_right;
    logic [SPEED_W-1:0] rate_left;
    logic [SPEED_W-1:0] rate_right;
    logic               step_active;
  } dwsc_res_t;

endpackage

// File: rtl/dwsc_in_if.sv
// Input channel: encoder counts and period length, valid/ready.
// Depends on dwsc_pkg for field widths.
`timescale 1ns / 1ps

interface dwsc_in_if;
  logic                          valid;
  logic                          ready;
  logic [dwsc_pkg::PULSE_W-1:0]  pulses_left;
  logic [dwsc_pkg::PULSE_W-1:0]  pulses_right;
  logic [dwsc_pkg::PERIOD_W-1:0] period_ms;

  modport source (output valid, output pulses_left, output pulses_right,
                  output period_ms, input ready);
  modport sink   (input valid, input pulses_left, input pulses_right,
                  input period_ms, output ready);
endinterface

// File: rtl/dwsc_out_if.sv
// Result channel: drives, measured speeds and step flag, valid/ready.
// Depends on dwsc_pkg for field widths.
`timescale 1ns / 1ps

interface dwsc_out_if;
  logic                         valid;
  logic                         ready;
  logic [dwsc_pkg::DUTY_W-1:0]  drive_left;
  logic [dwsc_pkg::DUTY_W-1:0]  drive_right;
  logic [dwsc_pkg::SPEED_W-1:0] rate_left;
  logic [dwsc_pkg::SPEED_W-1:0] rate_right;
  logic                         step_active;

  modport source (output valid, output drive_left, output drive_right,
                  output rate_left, output rate_right, output step_active,
                  input ready);
  modport sink   (input valid, input drive_left, input drive_right,
                  input rate_left, input rate_right, input step_active,
                  output ready);
endinterface

// File: rtl/dwsc_cfg_if.sv
// Configuration write channel: register index and data, valid/ready.
// Depends on dwsc_pkg for widths.
`timescale 1ns / 1ps

interface dwsc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dwsc_pkg::CFG_IDX_W-1:0]  index;
  logic [dwsc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/dual_wheel_speed_pi_control_unit.sv
// Top level of the dual-wheel speed PI controller.
// Depends on dwsc_pkg, the three channel interfaces, dwsc_ctrl and dwsc_datapath.
`timescale 1ns / 1ps

// Usage
// - in_ch: one beat per measurement period with both encoder counts and the
//   period length in ms (0 is taken as 1 ms). Accepted when valid and ready.
// - out_ch: one beat per input beat: both drives, both measured speeds
//   (Q4.12 rev/s, saturated) and the step-test flag.
// - cfg_ch: register index and data; ready whenever out of reset, written on
//   valid. Write only while no beat is in flight.
// Timing
// - Speed measurement runs a 16-step restoring divider per wheel, one
//   quotient bit a cycle; that divider sets the cost of a beat.
// - Closed-loop mode: divider for both wheels, S_ERR to S_DUTY per wheel,
//   S_OUT; step-test mode: divider, S_STEP, S_OUT. One beat in work at a
//   time: a new input beat is taken the cycle after the last result registers.
// - The result sits in an output register: a stalled receiver does not stop
//   the next input beat being taken and processed; only the final load of
//   the following result waits for the register to empty.
// Reset (rst_n low, synchronous): registers back to defaults, integrals,
// duties, step flag and run time cleared, no result pending.

module dual_wheel_speed_pi_control_unit (
  input  logic              clk,
  input  logic              rst_n,
  dwsc_in_if.sink           in_ch,
  dwsc_out_if.source        out_ch,
  dwsc_cfg_if.sink          cfg_ch
);

  dwsc_pkg::dwsc_cmd_t cmd;
  dwsc_pkg::dwsc_sts_t sts;
  dwsc_pkg::dwsc_in_t  in_beat;
  dwsc_pkg::dwsc_res_t res;
  logic                in_ready;
  logic                out_valid;

  // configuration writes never stall once out of reset
  assign cfg_ch.ready = rst_n;

  assign in_beat.pulses_left  = in_ch.pulses_left;
  assign in_beat.pulses_right = in_ch.pulses_right;
  assign in_beat.period_ms    = in_ch.period_ms;
  assign in_ch.ready          = in_ready;

  dwsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dwsc_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_beat  (in_beat),
    .cfg_we   (cfg_ch.valid),
    .cfg_idx  (cfg_ch.index),
    .cfg_data (cfg_ch.data),
    .sts      (sts),
    .res      (res)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.drive_left  = res.drive_left;
  assign out_ch.drive_right = res.drive_right;
  assign out_ch.rate_left   = res.rate_left;
  assign out_ch.rate_right  = res.rate_right;
  assign out_ch.step_active = res.step_active;

endmodule

// File: rtl/dwsc_ctrl.sv
// Sequencer of the speed controller: walks the datapath through one beat.
// Depends on dwsc_pkg (command and status types).
`timescale 1ns / 1ps

module dwsc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  dwsc_pkg::dwsc_sts_t sts,
  output dwsc_pkg::dwsc_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_NUM, S_CHK, S_DIV, S_SPD,
    S_ERR, S_MUL, S_RCP, S_ACC, S_PROD, S_DUTY,
    S_STEP, S_OUT
  } state_t;

  state_t                       state_r;
  logic                         wheel_r;
  logic [dwsc_pkg::BIT_W-1:0]   bit_r;
  logic                         out_valid_r;
  logic                         out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.wheel   = wheel_r;
    cmd.bit_idx = bit_r;
    cmd.op      = dwsc_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: if (in_valid) cmd.op = dwsc_pkg::OP_LOAD;
      S_NUM:  cmd.op = dwsc_pkg::OP_NUM;
      S_CHK:  cmd.op = dwsc_pkg::OP_CHK;
      S_DIV:  cmd.op = dwsc_pkg::OP_DIV;
      S_SPD:  cmd.op = dwsc_pkg::OP_SPD;
      S_ERR:  cmd.op = dwsc_pkg::OP_ERR;
      S_MUL:  cmd.op = dwsc_pkg::OP_MUL;
      S_RCP:  cmd.op = dwsc_pkg::OP_RCP;
      S_ACC:  cmd.op = dwsc_pkg::OP_ACC;
      S_PROD: cmd.op = dwsc_pkg::OP_PROD;
      S_DUTY: cmd.op = dwsc_pkg::OP_DUTY;
      S_STEP: cmd.op = dwsc_pkg::OP_STEP;
      S_OUT:  if (out_free) cmd.op = dwsc_pkg::OP_OUT;
      default: cmd.op = dwsc_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wheel_r     <= 1'b0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_NUM;
            wheel_r <= 1'b0;
          end
        end
        S_NUM: state_r <= S_CHK;
        S_CHK: begin
          state_r <= S_DIV;
          bit_r   <= '1;
        end
        S_DIV: begin
          if (bit_r == '0) state_r <= S_SPD;
          else bit_r <= bit_r - 1'b1;
        end
        S_SPD: begin
          if (!wheel_r) begin
            wheel_r <= 1'b1;
            state_r <= S_NUM;
          end else begin
            wheel_r <= 1'b0;
            state_r <= sts.step_mode ? S_STEP : S_ERR;
          end
        end
        S_ERR:  state_r <= S_MUL;
        S_MUL:  state_r <= S_RCP;
        S_RCP:  state_r <= S_ACC;
        S_ACC:  state_r <= S_PROD;
        S_PROD: state_r <= S_DUTY;
        S_DUTY: begin
          if (!wheel_r) begin
            wheel_r <= 1'b1;
            state_r <= S_ERR;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_STEP: state_r <= S_OUT;
        S_OUT: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/dwsc_datapath.sv
// Datapath: configuration registers, speed divider, PI arithmetic, state.
// Depends on dwsc_pkg; driven by dwsc_ctrl commands.
`timescale 1ns / 1ps

module dwsc_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dwsc_pkg::dwsc_cmd_t                 cmd,
  input  dwsc_pkg::dwsc_in_t                  in_beat,
  input  logic                                cfg_we,
  input  logic [dwsc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [dwsc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output dwsc_pkg::dwsc_sts_t                 sts,
  output dwsc_pkg::dwsc_res_t                 res
);

  localparam int PULSE_W  = dwsc_pkg::PULSE_W;
  localparam int PERIOD_W = dwsc_pkg::PERIOD_W;
  localparam int SPEED_W  = dwsc_pkg::SPEED_W;
  localparam int DUTY_W   = dwsc_pkg::DUTY_W;
  localparam int GAIN_W   = dwsc_pkg::GAIN_W;
  localparam int ACC_W    = dwsc_pkg::ACC_W;
  localparam int TIME_W   = dwsc_pkg::TIME_W;
  localparam int NUM_W    = dwsc_pkg::NUM_W;
  localparam int DEN_W    = dwsc_pkg::DEN_W;
  localparam int DIV_W    = dwsc_pkg::DIV_W;
  localparam int RP_W     = dwsc_pkg::RP_W;
  localparam int QUO_W    = dwsc_pkg::QUO_W;
  localparam int ERR_W    = dwsc_pkg::ERR_W;
  localparam int PTERM_W  = dwsc_pkg::PTERM_W;
  localparam int ITERM_W  = dwsc_pkg::ITERM_W;
  localparam int TOTAL_W  = dwsc_pkg::TOTAL_W;
  localparam int FRAC_W   = dwsc_pkg::FRAC_W;
  localparam int IP_W     = ERR_W + PERIOD_W + 1;
  localparam int SUM_W    = ACC_W + 2;

  // configuration
  logic                step_mode_r;
  logic [SPEED_W-1:0]  target_l_r, target_r_r;
  logic [GAIN_W-1:0]   kp_l_r, ki_l_r, kp_r_r, ki_r_r;
  logic [DUTY_W-1:0]   step_drive_r;

  // architectural state
  logic signed [ACC_W-1:0] acc_l_r, acc_r_r;
  logic [DUTY_W-1:0]       duty_l_r, duty_r_r;
  logic                    step_on_r;
  logic [TIME_W-1:0]       run_time_r;

  // working registers
  logic [PULSE_W-1:0]        pl_r, pr_r;
  logic [PERIOD_W-1:0]       period_r;
  logic [DEN_W-1:0]          den_r;
  logic [NUM_W-1:0]          rem_r;
  logic                      sat_r;
  logic [SPEED_W-1:0]        q_r;
  logic [SPEED_W-1:0]        speed_l_r, speed_r_r;
  logic signed [ERR_W-1:0]   err_r;
  logic [NUM_W-1:0]          mag_r;
  logic                      neg_r;
  logic [QUO_W-1:0]          quo_r;
  logic signed [PTERM_W-1:0] pterm_r;
  logic signed [ITERM_W-1:0] iterm_r;
  dwsc_pkg::dwsc_res_t       res_r;

  // combinational
  logic [PERIOD_W-1:0]       period_fix;
  logic [DEN_W-1:0]          den_nxt;
  logic [TIME_W:0]           time_sum;
  logic [TIME_W-1:0]         time_nxt;
  logic [PULSE_W-1:0]        pulses_sel;
  logic [NUM_W-1:0]          num_nxt;
  logic [DIV_W-1:0]          den_top, trial;
  logic                      sat_nxt, take;
  logic [SPEED_W-1:0]        target_sel, speed_sel;
  logic [GAIN_W-1:0]         kp_sel, ki_sel;
  logic signed [ACC_W-1:0]   acc_sel;
  logic [DUTY_W-1:0]         duty_sel;
  logic signed [ERR_W-1:0]   err_nxt;
  logic signed [IP_W-1:0]    ip;
  logic [IP_W-1:0]           ip_mag;
  logic [RP_W-1:0]           rp;
  logic signed [SUM_W-1:0]   inc, sum;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [PTERM_W-1:0] pterm_nxt;
  logic signed [ITERM_W-1:0] iterm_nxt;
  logic signed [TOTAL_W-1:0] total;
  logic [DUTY_W-1:0]         duty_nxt;
  logic                      step_go, step_stop;

  assign period_fix = (in_beat.period_ms == '0) ? PERIOD_W'(1) : in_beat.period_ms;
  assign den_nxt    = DEN_W'(period_fix) * DEN_W'(dwsc_pkg::SLOTS_PER_REV);
  assign time_sum   = {1'b0, run_time_r} + (TIME_W + 1)'(period_fix);
  assign time_nxt   = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];

  assign pulses_sel = cmd.wheel ? pr_r : pl_r;
  assign num_nxt    = NUM_W'(pulses_sel) * dwsc_pkg::NUM_SCALE;

  // restoring division; the dividend stays below den << SPEED_W once unsaturated
  assign den_top = {den_r, {SPEED_W{1'b0}}};
  assign sat_nxt = DIV_W'(rem_r) >= den_top;
  assign trial   = DIV_W'(den_r) << cmd.bit_idx;
  assign take    = DIV_W'(rem_r) >= trial;

  assign target_sel = cmd.wheel ? target_r_r : target_l_r;
  assign speed_sel  = cmd.wheel ? speed_r_r  : speed_l_r;
  assign kp_sel     = cmd.wheel ? kp_r_r     : kp_l_r;
  assign ki_sel     = cmd.wheel ? ki_r_r     : ki_l_r;
  assign acc_sel    = cmd.wheel ? acc_r_r    : acc_l_r;
  assign duty_sel   = cmd.wheel ? duty_r_r   : duty_l_r;

  assign err_nxt = $signed({1'b0, target_sel}) - $signed({1'b0, speed_sel});
  assign ip      = IP_W'(err_r) * $signed({1'b0, period_r});
  assign ip_mag  = ip[IP_W-1] ? IP_W'(-ip) : IP_W'(ip);
  assign rp      = RP_W'(mag_r) * RP_W'(dwsc_pkg::RECIP_M);

  // integral update, truncated toward zero, saturated to 32 bits signed
  assign inc = neg_r ? -$signed(SUM_W'(quo_r)) : $signed(SUM_W'(quo_r));
  assign sum = $signed({{2{acc_sel[ACC_W-1]}}, acc_sel}) + inc;
  always_comb begin
    if (sum[SUM_W-1] == sum[SUM_W-2] && sum[SUM_W-2] == sum[ACC_W-1])
      acc_nxt = sum[ACC_W-1:0];
    else if (sum[SUM_W-1])
      acc_nxt = {1'b1, {(ACC_W-1){1'b0}}};
    else
      acc_nxt = {1'b0, {(ACC_W-1){1'b1}}};
  end

  assign pterm_nxt = PTERM_W'($signed({1'b0, kp_sel})) * PTERM_W'(err_r);
  assign iterm_nxt = ITERM_W'($signed({1'b0, ki_sel})) * ITERM_W'(acc_sel);

  // negative totals truncate to zero or below, so they all land on 0
  assign total = $signed({{(TOTAL_W-DUTY_W-FRAC_W){1'b0}}, duty_sel, {FRAC_W{1'b0}}})
               + TOTAL_W'(pterm_r) + TOTAL_W'(iterm_r);
  always_comb begin
    if (total[TOTAL_W-1])
      duty_nxt = '0;
    else if (|total[TOTAL_W-2:FRAC_W+DUTY_W])
      duty_nxt = '1;
    else
      duty_nxt = total[FRAC_W+DUTY_W-1:FRAC_W];
  end

  assign step_go   = (run_time_r >= dwsc_pkg::STEP_START_MS) && !step_on_r
                  && (run_time_r < dwsc_pkg::STEP_START_MS + dwsc_pkg::STEP_LEN_MS);
  assign step_stop = (run_time_r >= dwsc_pkg::STEP_START_MS + dwsc_pkg::STEP_LEN_MS)
                  && step_on_r;

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_mode_r  <= 1'b0;
      target_l_r   <= SPEED_W'(6144);
      target_r_r   <= SPEED_W'(6144);
      kp_l_r       <= GAIN_W'(3072);
      ki_l_r       <= GAIN_W'(46);
      kp_r_r       <= GAIN_W'(3328);
      ki_r_r       <= GAIN_W'(72);
      step_drive_r <= DUTY_W'(200);
      acc_l_r      <= '0;
      acc_r_r      <= '0;
      duty_l_r     <= '0;
      duty_r_r     <= '0;
      step_on_r    <= 1'b0;
      run_time_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (dwsc_pkg::cfg_reg_t'(cfg_idx))
          dwsc_pkg::CFG_STEP_MODE:   step_mode_r  <= cfg_data[0];
          dwsc_pkg::CFG_TARGET_L:    target_l_r   <= cfg_data;
          dwsc_pkg::CFG_TARGET_R:    target_r_r   <= cfg_data;
          dwsc_pkg::CFG_PROP_GAIN_L: kp_l_r       <= cfg_data;
          dwsc_pkg::CFG_INT_GAIN_L:  ki_l_r       <= cfg_data;
          dwsc_pkg::CFG_PROP_GAIN_R: kp_r_r       <= cfg_data;
          dwsc_pkg::CFG_INT_GAIN_R:  ki_r_r       <= cfg_data;
          dwsc_pkg::CFG_STEP_DRIVE:  step_drive_r <= cfg_data[DUTY_W-1:0];
          default: ;
        endcase
      end
      unique case (cmd.op)
        dwsc_pkg::OP_LOAD: run_time_r <= time_nxt;
        dwsc_pkg::OP_ACC: begin
          if (cmd.wheel) acc_r_r <= acc_nxt;
          else acc_l_r <= acc_nxt;
        end
        dwsc_pkg::OP_DUTY: begin
          if (cmd.wheel) duty_r_r <= duty_nxt;
          else duty_l_r <= duty_nxt;
        end
        dwsc_pkg::OP_STEP: begin
          if (step_go) begin
            step_on_r <= 1'b1;
            duty_l_r  <= step_drive_r;
            duty_r_r  <= step_drive_r;
          end else if (step_stop) begin
            step_on_r <= 1'b0;
            duty_l_r  <= '0;
            duty_r_r  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      dwsc_pkg::OP_LOAD: begin
        pl_r     <= in_beat.pulses_left;
        pr_r     <= in_beat.pulses_right;
        period_r <= period_fix;
        den_r    <= den_nxt;
      end
      dwsc_pkg::OP_NUM: rem_r <= num_nxt;
      dwsc_pkg::OP_CHK: begin
        sat_r <= sat_nxt;
        q_r   <= '0;
      end
      dwsc_pkg::OP_DIV: begin
        if (!sat_r && take) begin
          rem_r            <= rem_r - trial[NUM_W-1:0];
          q_r[cmd.bit_idx] <= 1'b1;
        end
      end
      dwsc_pkg::OP_SPD: begin
        if (cmd.wheel) speed_r_r <= sat_r ? '1 : q_r;
        else speed_l_r <= sat_r ? '1 : q_r;
      end
      dwsc_pkg::OP_ERR: err_r <= err_nxt;
      dwsc_pkg::OP_MUL: begin
        mag_r <= ip_mag[NUM_W-1:0];
        neg_r <= ip[IP_W-1];
      end
      dwsc_pkg::OP_RCP: quo_r <= rp[RP_W-1:dwsc_pkg::RECIP_SH];
      dwsc_pkg::OP_PROD: begin
        pterm_r <= pterm_nxt;
        iterm_r <= iterm_nxt;
      end
      dwsc_pkg::OP_OUT: begin
        res_r.drive_left  <= duty_l_r;
        res_r.drive_right <= duty_r_r;
        res_r.rate_left   <= speed_l_r;
        res_r.rate_right  <= speed_r_r;
        res_r.step_active <= step_on_r;
      end
      default: ;
    endcase
  end

  assign sts.step_mode = step_mode_r;
  assign res           = res_r;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for dual_wheel_speed_pi_control_unit.
// Depends on dwsc_pkg, dwsc_in_if, dwsc_out_if, dwsc_cfg_if and the RTL below them.
// Result beats are checked against an in-bench model of the two PI loops.

localparam longint ACC_TOP = 64'sd2147483647;
localparam longint ACC_BOT = -64'sd2147483648;

// Keeps the register copy and the loop state; predicts one result per input beat.
class drive_ledger;
  logic        step_mode;
  logic [15:0] target [2];   // index 0 left, 1 right
  logic [15:0] kp [2];
  logic [15:0] ki [2];
  logic [7:0]  step_drv;

  int          integral [2];
  logic [7:0]  duty [2];
  logic        step_on;
  logic [31:0] run_ms;

  dwsc_pkg::dwsc_res_t owed_drives [$];
  int          errors;

  function new();
    step_mode = 1'b0;
    target    = '{16'd6144, 16'd6144};
    kp        = '{16'd3072, 16'd3328};
    ki        = '{16'd46, 16'd72};
    step_drv  = 8'd200;
    integral  = '{0, 0};
    duty      = '{8'd0, 8'd0};
    step_on   = 1'b0;
    run_ms    = '0;
    errors    = 0;
  endfunction

  function void set_reg(dwsc_pkg::cfg_reg_t idx, logic [15:0] v);
    case (idx)
      dwsc_pkg::CFG_STEP_MODE:   step_mode = v[0];
      dwsc_pkg::CFG_TARGET_L:    target[0] = v;
      dwsc_pkg::CFG_TARGET_R:    target[1] = v;
      dwsc_pkg::CFG_PROP_GAIN_L: kp[0] = v;
      dwsc_pkg::CFG_INT_GAIN_L:  ki[0] = v;
      dwsc_pkg::CFG_PROP_GAIN_R: kp[1] = v;
      dwsc_pkg::CFG_INT_GAIN_R:  ki[1] = v;
      dwsc_pkg::CFG_STEP_DRIVE:  step_drv = v[7:0];
      default: ;
    endcase
  endfunction

  // Q4.12 rev/s, truncated, saturated
  function logic [15:0] rate_of(logic [9:0] pulses, longint unsigned per);
    longint unsigned q;
    q = (64'(pulses) * 64'd4096000) / (64'(dwsc_pkg::SLOTS_PER_REV) * per);
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  function void pi_step(int w, logic [15:0] rate, longint per);
    longint err, inc, sum, total;
    err = longint'(target[w]) - longint'(rate);
    inc = (err * per) / 1000;
    sum = longint'(integral[w]) + inc;
    if (sum > ACC_TOP) sum = ACC_TOP;
    if (sum < ACC_BOT) sum = ACC_BOT;
    integral[w] = int'(sum);
    // Q.20 sum, truncated toward zero, then clamped
    total = longint'(duty[w]) * 1048576 + longint'(kp[w]) * err + longint'(ki[w]) * sum;
    total = total / 1048576;
    if (total < 0) total = 0;
    else if (total > 255) total = 255;
    duty[w] = total[7:0];
  endfunction

  function void note_period(dwsc_pkg::dwsc_in_t beat);
    longint unsigned     per, t;
    logic [15:0]         rl, rr;
    dwsc_pkg::dwsc_res_t due;
    per = (beat.period_ms == 0) ? 64'd1 : 64'(beat.period_ms);
    rl  = rate_of(beat.pulses_left, per);
    rr  = rate_of(beat.pulses_right, per);
    t   = 64'(run_ms) + per;
    run_ms = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
    if (step_mode) begin
      if (run_ms >= dwsc_pkg::STEP_START_MS && !step_on &&
          run_ms < dwsc_pkg::STEP_START_MS + dwsc_pkg::STEP_LEN_MS) begin
        step_on = 1'b1;
        duty    = '{step_drv, step_drv};
      end else if (run_ms >= dwsc_pkg::STEP_START_MS + dwsc_pkg::STEP_LEN_MS && step_on) begin
        step_on = 1'b0;
        duty    = '{8'd0, 8'd0};
      end
    end else begin
      pi_step(0, rl, longint'(per));
      pi_step(1, rr, longint'(per));
    end
    due.drive_left  = duty[0];
    due.drive_right = duty[1];
    due.rate_left   = rl;
    due.rate_right  = rr;
    due.step_active = step_on;
    owed_drives.push_back(due);
  endfunction

  function void compare_field(string field, logic [15:0] due_v, logic [15:0] got_v);
    if (got_v !== due_v) begin
      $error("%s: expected %0d, actual %0d", field, due_v, got_v);
      errors++;
    end
  endfunction

  function void check_drive(dwsc_pkg::dwsc_res_t got);
    dwsc_pkg::dwsc_res_t due;
    if (owed_drives.size() == 0) begin
      $error("result beat with no prediction outstanding");
      errors++;
      return;
    end
    due = owed_drives.pop_front();
    compare_field("drive_left", 16'(due.drive_left), 16'(got.drive_left));
    compare_field("drive_right", 16'(due.drive_right), 16'(got.drive_right));
    compare_field("rate_left", due.rate_left, got.rate_left);
    compare_field("rate_right", due.rate_right, got.rate_right);
    compare_field("step_active", 16'(due.step_active), 16'(got.step_active));
  endfunction

  function int pending();
    return owed_drives.size();
  endfunction
endclass

module tb;

  // Limit on the run length: the slowest legal run is about 2300 beats, each
  // stretched by the longest gaps and stalls; the limit leaves headroom
  // above it.
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int RANDOM_ITEMS = 1400;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned cycles = 0;
  bit          gaps_on;      // sender inserts idle cycles between beats
  bit          stalls_on;    // receiver drops ready at random
  int unsigned stall_left;

  drive_ledger ledger;

  dwsc_in_if  in_bus ();
  dwsc_out_if res_bus ();
  dwsc_cfg_if cfg_bus ();

  dual_wheel_speed_pi_control_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (res_bus),
    .cfg_ch (cfg_bus)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a lost beat or a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Monitor: both channels sampled at the rising edge. Stimulus only moves
  // on the falling edge, so nothing here races with the drivers.
  always @(posedge clk) begin : watch
    dwsc_pkg::dwsc_in_t  got_in;
    dwsc_pkg::dwsc_res_t got_res;
    if (rst_n === 1'b1) begin
      if (in_bus.valid && in_bus.ready) begin
        got_in.pulses_left  = in_bus.pulses_left;
        got_in.pulses_right = in_bus.pulses_right;
        got_in.period_ms    = in_bus.period_ms;
        ledger.note_period(got_in);
      end
      if (res_bus.valid && res_bus.ready) begin
        got_res.drive_left  = res_bus.drive_left;
        got_res.drive_right = res_bus.drive_right;
        got_res.rate_left   = res_bus.rate_left;
        got_res.rate_right  = res_bus.rate_right;
        got_res.step_active = res_bus.step_active;
        ledger.check_drive(got_res);
      end
    end
  end

  // Idle / stall lengths: mostly none or short, now and then long enough to
  // outlast a whole beat of work so the gap lands on every stage.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(5, 120);
  endfunction

  // Field value with the all-zero and all-one corners weighted in.
  function automatic logic [15:0] pick_bits(int unsigned w);
    logic [15:0] ones;
    ones = 16'((32'd1 << w) - 1);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ones;
      default: return 16'($urandom) & ones;
    endcase
  endfunction

  // Register value for a random phase: mostly plausible tuning, sometimes
  // the full range. Unused upper data bits carry noise.
  function automatic logic [15:0] setting_for(dwsc_pkg::cfg_reg_t r);
    logic [15:0] v;
    v = 16'($urandom);
    case (r)
      dwsc_pkg::CFG_STEP_MODE:  v[0] = ($urandom_range(0, 4) == 0);   // mostly closed loop
      dwsc_pkg::CFG_STEP_DRIVE: v[7:0] = 8'(pick_bits(8));
      dwsc_pkg::CFG_TARGET_L, dwsc_pkg::CFG_TARGET_R: begin
        if ($urandom_range(0, 3) != 0) v = 16'($urandom_range(0, 16384));
        else v = pick_bits(16);
      end
      dwsc_pkg::CFG_PROP_GAIN_L, dwsc_pkg::CFG_PROP_GAIN_R: begin
        if ($urandom_range(0, 3) != 0) v = 16'($urandom_range(0, 8192));
        else v = pick_bits(16);
      end
      default: begin
        if ($urandom_range(0, 3) != 0) v = 16'($urandom_range(0, 400));
        else v = pick_bits(16);
      end
    endcase
    return v;
  endfunction

  // Register write; caller makes sure no beat is in flight.
  task automatic write_reg(dwsc_pkg::cfg_reg_t idx, logic [15:0] val);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    ledger.set_reg(idx, val);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // One input beat. Entered and left on a falling edge; valid stays high
  // after the handshake so back-to-back beats keep it up.
  task automatic send_period(logic [9:0] pl, logic [9:0] pr, logic [15:0] per);
    int unsigned idle;
    idle = gaps_on ? gap_len() : 0;
    if (idle != 0) begin
      in_bus.valid = 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_bus.valid        = 1'b1;
    in_bus.pulses_left  = pl;
    in_bus.pulses_right = pr;
    in_bus.period_ms    = per;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Every beat yields a result, so an empty ledger means the block is idle.
  task automatic wait_idle();
    in_bus.valid = 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
  endtask

  // Receiver: ready toggled on the falling edge with random stalls.
  initial begin
    res_bus.ready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        res_bus.ready = 1'b0;
        stall_left--;
      end else begin
        res_bus.ready = 1'b1;
        if (stalls_on && $urandom_range(0, 5) == 0) stall_left = gap_len();
      end
    end
  end

  initial begin
    int done;
    int n;
    ledger = new();
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.pulses_left  = '0;
    in_bus.pulses_right = '0;
    in_bus.period_ms    = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = dwsc_pkg::CFG_STEP_MODE;
    cfg_bus.data        = '0;
    gaps_on             = 1'b0;
    stalls_on           = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    // --- Directed ---
    // The step window only exists once per run (time never goes back), so
    // the step test comes first, straight out of reset.
    write_reg(dwsc_pkg::CFG_STEP_MODE, 16'd1);
    write_reg(dwsc_pkg::CFG_STEP_DRIVE, 16'h00FF);
    send_period(10'd0, 10'd0, 16'd0);            // zero period taken as 1 ms
    send_period(10'h3FF, 10'h3FF, 16'd1);        // both rates saturate
    send_period(10'h3FF, 10'd0, 16'd1997);       // 1999 ms: one short of the step
    send_period(10'd0, 10'h3FF, 16'd1);          // 2000 ms: step applied
    send_period(10'd5, 10'd9, 16'd1000);         // held

    // Closed loop with the step flag still set: flag reported unchanged,
    // the loop starts from the step drive.
    wait_idle();
    write_reg(dwsc_pkg::CFG_STEP_MODE, 16'hFFFE);
    send_period(10'd300, 10'd300, 16'd1000);
    send_period(10'h3FF, 10'd1, 16'd1000);

    // Back to step test: hold just under 12 s, release at 12 s.
    wait_idle();
    write_reg(dwsc_pkg::CFG_STEP_MODE, 16'h0001);
    write_reg(dwsc_pkg::CFG_STEP_DRIVE, 16'hA500);
    send_period(10'd10, 10'd10, 16'd6999);
    send_period(10'd10, 10'd10, 16'd1);
    send_period(10'd0, 10'd0, 16'd0);

    // Closed loop at the register extremes, then mirrored.
    wait_idle();
    write_reg(dwsc_pkg::CFG_STEP_MODE, 16'd0);
    write_reg(dwsc_pkg::CFG_TARGET_L, 16'hFFFF);
    write_reg(dwsc_pkg::CFG_TARGET_R, 16'd0);
    write_reg(dwsc_pkg::CFG_PROP_GAIN_L, 16'hFFFF);
    write_reg(dwsc_pkg::CFG_INT_GAIN_L, 16'hFFFF);
    write_reg(dwsc_pkg::CFG_PROP_GAIN_R, 16'd0);
    write_reg(dwsc_pkg::CFG_INT_GAIN_R, 16'd0);
    send_period(10'd0, 10'h3FF, 16'hFFFF);
    send_period(10'h3FF, 10'd0, 16'd1);
    send_period(10'd0, 10'd0, 16'd0);
    send_period(10'h3FF, 10'h3FF, 16'hFFFF);
    send_period(10'd512, 10'd511, 16'd30000);
    wait_idle();
    write_reg(dwsc_pkg::CFG_TARGET_L, 16'd0);
    write_reg(dwsc_pkg::CFG_TARGET_R, 16'hFFFF);
    write_reg(dwsc_pkg::CFG_PROP_GAIN_L, 16'd0);
    write_reg(dwsc_pkg::CFG_INT_GAIN_L, 16'd0);
    write_reg(dwsc_pkg::CFG_PROP_GAIN_R, 16'hFFFF);
    write_reg(dwsc_pkg::CFG_INT_GAIN_R, 16'hFFFF);
    send_period(10'h3FF, 10'd0, 16'd1);
    send_period(10'd0, 10'h3FF, 16'hFFFF);
    send_period(10'd1, 10'd1, 16'd2);

    // --- Random phases ---
    // Each phase retunes some registers (all of them the first time) and
    // picks its own idling; some phases run flat out.
    done = 0;
    while (done < RANDOM_ITEMS) begin
      wait_idle();
      for (int i = 0; i < 8; i++)
        if (done == 0 || $urandom_range(0, 1) == 1)
          write_reg(dwsc_pkg::cfg_reg_t'(i), setting_for(dwsc_pkg::cfg_reg_t'(i)));
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(60, 250);
      repeat (n) begin
        logic [15:0] per;
        case ($urandom_range(0, 9))
          0:       per = pick_bits(16);
          1:       per = 16'($urandom_range(0, 3));
          default: per = 16'($urandom_range(50, 2000));
        endcase
        send_period(10'(pick_bits(10)), 10'(pick_bits(10)), per);
      end
      done += n;
    end

    // --- Long run: integral saturation ---
    // Near standstill against a full-scale target with the longest period:
    // each beat adds about 4.3M, so both integrals reach the positive limit
    // within a few hundred beats and then stay clamped.
    wait_idle();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_reg(dwsc_pkg::CFG_STEP_MODE, 16'd0);
    write_reg(dwsc_pkg::CFG_TARGET_L, 16'hFFFF);
    write_reg(dwsc_pkg::CFG_TARGET_R, 16'hFFFF);
    while (longint'(ledger.integral[0]) != ACC_TOP ||
           longint'(ledger.integral[1]) != ACC_TOP)
      send_period(10'($urandom_range(0, 15)), 10'($urandom_range(0, 15)), 16'hFFFF);
    send_period(10'd0, 10'd0, 16'hFFFF);

    // Drain, give the block one beat's latency to show anything spurious.
    wait_idle();
    repeat (64) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
